>>> rtl/dsm_pkg.sv
// ---------------------------------------------------------------------------
// Damaged shear modulus update: shared package
// Word format, saturating helpers, register indexes and the per-item
// context that travels down the pipeline.
// ---------------------------------------------------------------------------
package dsm_pkg;

    localparam int W   = 48;        // word width
    localparam int F   = 24;        // fraction bits
    localparam int WX  = W + 8;     // headroom for sums and small multiples
    localparam int PW  = 2 * W;     // full product width
    localparam int DW  = W + F;     // scaled dividend width
    localparam int XIW = 26;        // width of the invariant ratio field written to its register

    localparam int MUL_LAT = 3;
    localparam int SQ_LAT  = W;
    localparam int DIV_LAT = DW + 1;

    localparam int IN_TW   = 128;
    localparam int OUT_TW  = 192;
    localparam int D0_W    = 25;
    localparam int LAM_LSB = D0_W;
    localparam int MU_LSB  = D0_W + W;

    localparam logic [1:0] REG_XI  = 2'd0;
    localparam logic [1:0] REG_LAM = 2'd1;
    localparam logic [1:0] REG_MU  = 2'd2;
    localparam logic [1:0] REG_USE = 2'd3;

    localparam logic [5:0] K2  = 6'd2;
    localparam logic [5:0] K6  = 6'd6;
    localparam logic [5:0] K12 = 6'd12;
    localparam logic [5:0] K24 = 6'd24;
    localparam logic [5:0] K36 = 6'd36;

    typedef logic signed [W-1:0] word_t;

    localparam word_t WMAX      = {1'b0, {(W-1){1'b1}}};
    localparam word_t WMIN      = {1'b1, {(W-1){1'b0}}};
    localparam word_t NEG_THREE = word_t'(-(64'sd3 <<< F));
    localparam logic [127:0] MAGLIM = 128'(1) << (W - 1);

    typedef struct packed {
        logic            vld;
        word_t           lam;
        word_t           mu;
        word_t           x;
        word_t           d0;
        word_t           xd;
        word_t           x2;
        word_t           x4;
        word_t           lx2;
        word_t           mx2;
        word_t           denom;
        logic            flag;
        word_t           mu2;
        word_t           lam6;
        word_t           n12;
        word_t           n6;
        word_t           mu24;
        word_t           lam36;
        word_t           s;
        word_t           r1;
        word_t           xs;
        word_t           lx4;
        word_t           r2a;
        word_t           r2;
        logic            sq_ok;
        word_t           t1;
        word_t           t2;
        word_t           nm;
        word_t           np;
        word_t           gm;
        word_t           gp;
        word_t           gmx;
        word_t           gamma;
        word_t           prod;
        word_t           mu_eff;
        logic [W-2:0]    stiff;
    } ctx_t;

    function automatic word_t sat_wide(input logic signed [WX-1:0] v);
        if (v > WX'(WMAX))
            return WMAX;
        else if (v < WX'(WMIN))
            return WMIN;
        else
            return v[W-1:0];
    endfunction

    function automatic word_t sadd(input word_t a, input word_t b);
        return sat_wide(WX'(a) + WX'(b));
    endfunction

    function automatic word_t sneg(input word_t a);
        return sat_wide(-WX'(a));
    endfunction

    function automatic word_t mulk(input word_t a, input logic [5:0] k);
        return sat_wide(WX'(a) * WX'($signed({1'b0, k})));
    endfunction

    function automatic logic [W-1:0] mag(input word_t a);
        logic signed [W:0] e;
        e = {a[W-1], a};
        return a[W-1] ? W'(-e) : W'(e);
    endfunction

    // Signed word from sign and magnitude, saturated to the word range.
    function automatic word_t from_mag(input logic neg, input logic [127:0] m);
        logic signed [W:0] e;
        e = $signed({1'b0, m[W-1:0]});
        if (neg)
            return (m > MAGLIM) ? WMIN : word_t'(-e);
        else
            return (m > 128'(WMAX)) ? WMAX : m[W-1:0];
    endfunction

endpackage

>>> rtl/dsm_mul.sv
// ---------------------------------------------------------------------------
// Damaged shear modulus update: pipelined fixed-point multiplier
// Exact product from four half-width partial products, then round to
// nearest (ties away from zero) at the fraction point and saturate.
// ---------------------------------------------------------------------------
module dsm_mul (
    input  logic                   clk,
    input  logic                   en,
    input  dsm_pkg::word_t         a,
    input  dsm_pkg::word_t         b,
    output dsm_pkg::word_t         q,
    output logic [dsm_pkg::PW-1:0] pmag
);
    localparam int HL = dsm_pkg::W / 2;

    logic [dsm_pkg::W-1:0]  ma;
    logic [dsm_pkg::W-1:0]  mb;
    logic [dsm_pkg::W-1:0]  p00_reg;
    logic [dsm_pkg::W-1:0]  p01_reg;
    logic [dsm_pkg::W-1:0]  p10_reg;
    logic [dsm_pkg::W-1:0]  p11_reg;
    logic                   neg1_reg;
    logic [dsm_pkg::PW-1:0] sum_reg;
    logic                   neg2_reg;
    logic [dsm_pkg::PW-1:0] rnd;
    dsm_pkg::word_t         q_reg;
    logic [dsm_pkg::PW-1:0] mag_reg;

    assign ma  = dsm_pkg::mag(a);
    assign mb  = dsm_pkg::mag(b);
    assign rnd = sum_reg + (dsm_pkg::PW'(1) << (dsm_pkg::F - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg  <= dsm_pkg::W'(ma[HL-1:0]) * dsm_pkg::W'(mb[HL-1:0]);
            p01_reg  <= dsm_pkg::W'(ma[HL-1:0]) * dsm_pkg::W'(mb[dsm_pkg::W-1:HL]);
            p10_reg  <= dsm_pkg::W'(ma[dsm_pkg::W-1:HL]) * dsm_pkg::W'(mb[HL-1:0]);
            p11_reg  <= dsm_pkg::W'(ma[dsm_pkg::W-1:HL]) * dsm_pkg::W'(mb[dsm_pkg::W-1:HL]);
            neg1_reg <= a[dsm_pkg::W-1] ^ b[dsm_pkg::W-1];

            sum_reg  <= dsm_pkg::PW'(p00_reg)
                      + ((dsm_pkg::PW'(p01_reg) + dsm_pkg::PW'(p10_reg)) << HL)
                      + (dsm_pkg::PW'(p11_reg) << (2 * HL));
            neg2_reg <= neg1_reg;

            q_reg    <= dsm_pkg::from_mag(neg2_reg, 128'(rnd >> dsm_pkg::F));
            mag_reg  <= sum_reg;
        end
    end

    assign q    = q_reg;
    assign pmag = mag_reg;

endmodule

>>> rtl/dsm_div.sv
// ---------------------------------------------------------------------------
// Damaged shear modulus update: pipelined fixed-point divider
// Restoring division, one quotient bit per stage, then a rounding stage
// (ties away from zero) with saturation.
// ---------------------------------------------------------------------------
module dsm_div (
    input  logic           clk,
    input  logic           en,
    input  dsm_pkg::word_t n,
    input  dsm_pkg::word_t d,
    output dsm_pkg::word_t q
);
    typedef struct packed {
        logic [dsm_pkg::W:0]    r;
        logic [dsm_pkg::DW-1:0] q;
        logic [dsm_pkg::DW-1:0] num;
        logic [dsm_pkg::W-1:0]  den;
        logic                   neg;
    } dstg_t;

    function automatic dstg_t div_step(input dstg_t s);
        dstg_t               t;
        logic [dsm_pkg::W:0] rs;
        t  = s;
        rs = {s.r[dsm_pkg::W-1:0], s.num[dsm_pkg::DW-1]};
        if (rs >= {1'b0, s.den})
        begin
            t.r = rs - {1'b0, s.den};
            t.q = {s.q[dsm_pkg::DW-2:0], 1'b1};
        end
        else
        begin
            t.r = rs;
            t.q = {s.q[dsm_pkg::DW-2:0], 1'b0};
        end
        t.num = s.num << 1;
        return t;
    endfunction

    dstg_t                  init;
    dstg_t                  st_reg [dsm_pkg::DW];
    dstg_t                  last;
    logic                   half_up;
    logic [dsm_pkg::DW:0]   qq;
    dsm_pkg::word_t         q_reg;

    always_comb
    begin
        init     = '0;
        init.num = {dsm_pkg::mag(n), {dsm_pkg::F{1'b0}}};
        init.den = dsm_pkg::mag(d);
        init.neg = n[dsm_pkg::W-1] ^ d[dsm_pkg::W-1];
    end

    // Remainder is below the divisor, so twice it decides the rounding.
    assign last    = st_reg[dsm_pkg::DW-1];
    assign half_up = {last.r, 1'b0} >= {2'b00, last.den};
    assign qq      = {1'b0, last.q} + (dsm_pkg::DW + 1)'(half_up);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= div_step(init);
            for (int k = 1; k < dsm_pkg::DW; k++)
                st_reg[k] <= div_step(st_reg[k-1]);
            q_reg <= dsm_pkg::from_mag(last.neg, 128'(qq));
        end
    end

    assign q = q_reg;

endmodule

>>> rtl/dsm_sqrt.sv
// ---------------------------------------------------------------------------
// Damaged shear modulus update: pipelined integer square root
// Digit-by-digit floor square root of a double-width value, one root bit
// per stage.
// ---------------------------------------------------------------------------
module dsm_sqrt (
    input  logic                   clk,
    input  logic                   en,
    input  logic [dsm_pkg::PW-1:0] m,
    output logic [dsm_pkg::W-1:0]  root
);
    typedef struct packed {
        logic [dsm_pkg::W+1:0]  rem;
        logic [dsm_pkg::W-1:0]  root;
        logic [dsm_pkg::PW-1:0] num;
    } sstg_t;

    function automatic sstg_t sq_step(input sstg_t s);
        sstg_t                 t;
        logic [dsm_pkg::W+1:0] rs;
        logic [dsm_pkg::W+1:0] trial;
        logic                  ge;
        rs     = {s.rem[dsm_pkg::W-1:0], s.num[dsm_pkg::PW-1:dsm_pkg::PW-2]};
        trial  = {s.root, 2'b01};
        ge     = rs >= trial;
        t.rem  = ge ? rs - trial : rs;
        t.root = {s.root[dsm_pkg::W-2:0], ge};
        t.num  = s.num << 2;
        return t;
    endfunction

    sstg_t init;
    sstg_t st_reg [dsm_pkg::W];

    always_comb
    begin
        init     = '0;
        init.num = m;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= sq_step(init);
            for (int k = 1; k < dsm_pkg::W; k++)
                st_reg[k] <= sq_step(st_reg[k-1]);
        end
    end

    assign root = st_reg[dsm_pkg::W-1].root;

endmodule

>>> rtl/damaged_shear_modulus_update_unit.sv
// ---------------------------------------------------------------------------
// Damaged shear modulus update unit
// Per quadrature point: coupling modulus gamma_r from a quadratic in the
// reference invariant ratio, damaged shear modulus and its square root.
// ---------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         damage_initial, point_lambda, point_shear
//  m_*       out        lambda_out, shear_effective, coupling_modulus,
//                       stiffness_estimate; tuser = degenerate_flag
//  cfg_*     in         register writes, index 0..3
//
//  One item enters per cycle while the output is not stalled; the latency is
//  set mostly by the two 48-stage square roots and the 73-stage divider.
//  Reset clears the registers and all pipeline valid bits.
//  A stall at the output freezes the whole pipeline; s_tready drops only
//  while a result waits and m_tready is low.
// ---------------------------------------------------------------------------
module damaged_shear_modulus_update_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [dsm_pkg::W-1:0]      cfg_data,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // damage_initial [24:0], point_lambda [72:25], point_shear [120:73]
    input  logic [dsm_pkg::IN_TW-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // lambda_out [47:0], shear_effective [95:48], coupling_modulus [143:96],
    // stiffness_estimate [190:144]
    output logic [dsm_pkg::OUT_TW-1:0] m_tdata,
    // degenerate_flag [0]
    output logic [0:0]                 m_tuser
);
    localparam int ML = dsm_pkg::MUL_LAT;
    localparam int SL = dsm_pkg::SQ_LAT;
    localparam int VL = dsm_pkg::DIV_LAT;

    dsm_pkg::word_t xi_reg;
    dsm_pkg::word_t lam_reg;
    dsm_pkg::word_t mu_reg;
    logic           use_reg;
    logic           en;

    dsm_pkg::ctx_t c0_next, c0_reg;
    dsm_pkg::ctx_t d1_reg [ML];
    dsm_pkg::ctx_t c1;
    dsm_pkg::ctx_t d2_reg [ML];
    dsm_pkg::ctx_t c2;
    dsm_pkg::ctx_t c3_next, c3_reg;
    dsm_pkg::ctx_t c4_next, c4_reg;
    dsm_pkg::ctx_t d5_reg [ML];
    dsm_pkg::ctx_t c5;
    dsm_pkg::ctx_t c6_next, c6_reg;
    dsm_pkg::ctx_t c7_next, c7_reg;
    dsm_pkg::ctx_t d8_reg [ML];
    dsm_pkg::ctx_t d9_reg [SL];
    dsm_pkg::ctx_t c9;
    dsm_pkg::ctx_t c10_next, c10_reg;
    dsm_pkg::ctx_t d11_reg [VL];
    dsm_pkg::ctx_t c11;
    dsm_pkg::ctx_t d12_reg [ML];
    dsm_pkg::ctx_t c12;
    dsm_pkg::ctx_t c13_next, c13_reg;
    dsm_pkg::ctx_t d14_reg [ML];
    dsm_pkg::ctx_t c14;
    dsm_pkg::ctx_t c15_next, c15_reg;
    dsm_pkg::ctx_t d16_reg [SL];
    dsm_pkg::ctx_t c16;
    dsm_pkg::ctx_t out_reg;

    dsm_pkg::word_t m1a_q, m1b_q, m2a_q, m2b_q, m2c_q, m5a_q, m5b_q;
    dsm_pkg::word_t m12_q, m14_q, dm_q, dp_q;
    logic [dsm_pkg::PW-1:0] m8_mag;
    logic [dsm_pkg::PW-1:0] s9_in;
    logic [dsm_pkg::PW-1:0] s16_in;
    logic [dsm_pkg::W-1:0]  s9_root;
    logic [dsm_pkg::W-1:0]  s16_root;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xi_reg  <= '0;
            lam_reg <= '0;
            mu_reg  <= '0;
            use_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dsm_pkg::REG_XI:  xi_reg  <= dsm_pkg::word_t'($signed(cfg_data[dsm_pkg::XIW-1:0]));
                dsm_pkg::REG_LAM: lam_reg <= cfg_data;
                dsm_pkg::REG_MU:  mu_reg  <= cfg_data;
                dsm_pkg::REG_USE: use_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign en       = !out_reg.vld || m_tready;
    assign s_tready = en;

    // Input stage: operand selection.
    always_comb
    begin
        c0_next     = '0;
        c0_next.vld = s_tvalid;
        c0_next.x   = xi_reg;
        c0_next.d0  = dsm_pkg::word_t'(s_tdata[dsm_pkg::D0_W-1:0]);
        c0_next.lam = use_reg ? s_tdata[dsm_pkg::LAM_LSB +: dsm_pkg::W] : lam_reg;
        c0_next.mu  = use_reg ? s_tdata[dsm_pkg::MU_LSB +: dsm_pkg::W] : mu_reg;
    end

    // x^2 and x*d0.
    dsm_mul u_m1a (.clk(clk), .en(en), .a(c0_reg.x), .b(c0_reg.x), .q(m1a_q), .pmag());
    dsm_mul u_m1b (.clk(clk), .en(en), .a(c0_reg.x), .b(c0_reg.d0), .q(m1b_q), .pmag());

    always_comb
    begin
        c1    = d1_reg[ML-1];
        c1.x2 = m1a_q;
        c1.xd = m1b_q;
    end

    // x^4, lambda*x^2, mu*x^2.
    dsm_mul u_m2a (.clk(clk), .en(en), .a(c1.x2), .b(c1.x2), .q(m2a_q), .pmag());
    dsm_mul u_m2b (.clk(clk), .en(en), .a(c1.lam), .b(c1.x2), .q(m2b_q), .pmag());
    dsm_mul u_m2c (.clk(clk), .en(en), .a(c1.mu), .b(c1.x2), .q(m2c_q), .pmag());

    always_comb
    begin
        c2     = d2_reg[ML-1];
        c2.x4  = m2a_q;
        c2.lx2 = m2b_q;
        c2.mx2 = m2c_q;
    end

    // Small multiples and the denominator.
    always_comb
    begin
        c3_next       = c2;
        c3_next.denom = dsm_pkg::mulk(dsm_pkg::sadd(c2.x2, dsm_pkg::NEG_THREE), dsm_pkg::K2);
        c3_next.mu2   = dsm_pkg::mulk(c2.mu, dsm_pkg::K2);
        c3_next.lam6  = dsm_pkg::mulk(c2.lam, dsm_pkg::K6);
        c3_next.n12   = dsm_pkg::sneg(dsm_pkg::mulk(c2.lx2, dsm_pkg::K12));
        c3_next.n6    = dsm_pkg::sneg(dsm_pkg::mulk(c2.mx2, dsm_pkg::K6));
        c3_next.mu24  = dsm_pkg::mulk(c2.mu, dsm_pkg::K24);
        c3_next.lam36 = dsm_pkg::mulk(c2.lam, dsm_pkg::K36);
    end

    always_comb
    begin
        c4_next      = c3_reg;
        c4_next.flag = (c3_reg.denom == '0);
        c4_next.s    = dsm_pkg::sadd(dsm_pkg::sadd(dsm_pkg::sneg(c3_reg.lx2), c3_reg.lam6),
                                     c3_reg.mu2);
        c4_next.r1   = dsm_pkg::sadd(c3_reg.lx2, c3_reg.mu2);
    end

    // x*s and lambda*x^4.
    dsm_mul u_m5a (.clk(clk), .en(en), .a(c4_reg.x), .b(c4_reg.s), .q(m5a_q), .pmag());
    dsm_mul u_m5b (.clk(clk), .en(en), .a(c4_reg.lam), .b(c4_reg.x4), .q(m5b_q), .pmag());

    always_comb
    begin
        c5     = d5_reg[ML-1];
        c5.xs  = m5a_q;
        c5.lx4 = m5b_q;
    end

    always_comb
    begin
        c6_next     = c5;
        c6_next.t1  = dsm_pkg::sneg(c5.xs);
        c6_next.r2a = dsm_pkg::sadd(dsm_pkg::sadd(c5.lx4, c5.n12), c5.lam36);
    end

    // The radicand is usable when both factors share a sign or one is zero.
    always_comb
    begin
        c7_next       = c6_reg;
        c7_next.r2    = dsm_pkg::sadd(dsm_pkg::sadd(c6_reg.r2a, c6_reg.n6), c6_reg.mu24);
        c7_next.sq_ok = (c6_reg.r1[dsm_pkg::W-1] == c7_next.r2[dsm_pkg::W-1])
                     || (c6_reg.r1 == '0) || (c7_next.r2 == '0);
    end

    dsm_mul u_m8 (.clk(clk), .en(en), .a(c7_reg.r1), .b(c7_reg.r2), .q(), .pmag(m8_mag));

    assign s9_in = d8_reg[ML-1].sq_ok ? m8_mag : '0;

    dsm_sqrt u_s9 (.clk(clk), .en(en), .m(s9_in), .root(s9_root));

    always_comb
    begin
        c9    = d9_reg[SL-1];
        c9.t2 = dsm_pkg::from_mag(1'b0, 128'(s9_root));
    end

    always_comb
    begin
        c10_next    = c9;
        c10_next.nm = dsm_pkg::sadd(c9.t1, dsm_pkg::sneg(c9.t2));
        c10_next.np = dsm_pkg::sadd(c9.t1, c9.t2);
    end

    dsm_div u_dm (.clk(clk), .en(en), .n(c10_reg.nm), .d(c10_reg.denom), .q(dm_q));
    dsm_div u_dp (.clk(clk), .en(en), .n(c10_reg.np), .d(c10_reg.denom), .q(dp_q));

    always_comb
    begin
        c11    = d11_reg[VL-1];
        c11.gm = dm_q;
        c11.gp = dp_q;
    end

    dsm_mul u_m12 (.clk(clk), .en(en), .a(c11.gm), .b(c11.x), .q(m12_q), .pmag());

    always_comb
    begin
        c12     = d12_reg[ML-1];
        c12.gmx = m12_q;
    end

    // Root choice; a zero denominator forces the coupling modulus to zero.
    always_comb
    begin
        dsm_pkg::word_t bm;
        bm             = dsm_pkg::sadd(c12.mu2, dsm_pkg::sneg(c12.gmx));
        c13_next       = c12;
        c13_next.gamma = c12.flag ? '0 : ((bm > 0) ? c12.gm : c12.gp);
    end

    dsm_mul u_m14 (.clk(clk), .en(en), .a(c13_reg.xd), .b(c13_reg.gamma), .q(m14_q), .pmag());

    always_comb
    begin
        c14      = d14_reg[ML-1];
        c14.prod = m14_q;
    end

    always_comb
    begin
        c15_next        = c14;
        c15_next.mu_eff = dsm_pkg::sadd(c14.mu, c14.prod);
    end

    assign s16_in = (c15_reg.mu_eff > 0)
                  ? {{(dsm_pkg::PW - dsm_pkg::W - dsm_pkg::F){1'b0}}, c15_reg.mu_eff,
                     {dsm_pkg::F{1'b0}}}
                  : '0;

    dsm_sqrt u_s16 (.clk(clk), .en(en), .m(s16_in), .root(s16_root));

    always_comb
    begin
        c16       = d16_reg[SL-1];
        c16.stiff = s16_root[dsm_pkg::W-2:0];
    end

    // Pipeline registers and delay lines around the arithmetic units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c0_reg  <= '0;
            c3_reg  <= '0;
            c4_reg  <= '0;
            c6_reg  <= '0;
            c7_reg  <= '0;
            c10_reg <= '0;
            c13_reg <= '0;
            c15_reg <= '0;
            out_reg <= '0;
            for (int i = 0; i < ML; i++)
            begin
                d1_reg[i]  <= '0;
                d2_reg[i]  <= '0;
                d5_reg[i]  <= '0;
                d8_reg[i]  <= '0;
                d12_reg[i] <= '0;
                d14_reg[i] <= '0;
            end
            for (int i = 0; i < SL; i++)
            begin
                d9_reg[i]  <= '0;
                d16_reg[i] <= '0;
            end
            for (int i = 0; i < VL; i++)
                d11_reg[i] <= '0;
        end
        else if (en)
        begin
            c0_reg  <= c0_next;
            c3_reg  <= c3_next;
            c4_reg  <= c4_next;
            c6_reg  <= c6_next;
            c7_reg  <= c7_next;
            c10_reg <= c10_next;
            c13_reg <= c13_next;
            c15_reg <= c15_next;
            out_reg <= c16;

            d1_reg[0]  <= c0_reg;
            d2_reg[0]  <= c1;
            d5_reg[0]  <= c4_reg;
            d8_reg[0]  <= c7_reg;
            d12_reg[0] <= c11;
            d14_reg[0] <= c13_reg;
            d9_reg[0]  <= d8_reg[ML-1];
            d16_reg[0] <= c15_reg;
            d11_reg[0] <= c10_reg;
            for (int i = 1; i < ML; i++)
            begin
                d1_reg[i]  <= d1_reg[i-1];
                d2_reg[i]  <= d2_reg[i-1];
                d5_reg[i]  <= d5_reg[i-1];
                d8_reg[i]  <= d8_reg[i-1];
                d12_reg[i] <= d12_reg[i-1];
                d14_reg[i] <= d14_reg[i-1];
            end
            for (int i = 1; i < SL; i++)
            begin
                d9_reg[i]  <= d9_reg[i-1];
                d16_reg[i] <= d16_reg[i-1];
            end
            for (int i = 1; i < VL; i++)
                d11_reg[i] <= d11_reg[i-1];
        end
    end

    assign m_tvalid = out_reg.vld;
    assign m_tdata  = {1'b0, out_reg.stiff, out_reg.gamma, out_reg.mu_eff, out_reg.lam};
    assign m_tuser  = out_reg.flag;

    // A degenerate item carries a zero coupling modulus.
    a_flag_zero_gamma: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (out_reg.gamma == '0))
        else $error("degenerate item with nonzero coupling modulus");

    // A nonzero stiffness needs a positive damaged shear modulus.
    a_stiff_positive: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_reg.stiff != '0)) |-> (!out_reg.mu_eff[dsm_pkg::W-1]
                                                 && (out_reg.mu_eff != '0)))
        else $error("stiffness from a non-positive shear modulus");

    // The input side only stalls behind a waiting result.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a blocked result");

    // A stalled pipeline keeps its entry stage.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(c0_reg))
        else $error("entry stage changed during a stall");

endmodule

>>> tb/damaged_shear_modulus_update_unit_tb.sv
// ---------------------------------------------------------------------------
// Damaged shear modulus update unit testbench
// Streams quadrature points through the unit under several register
// settings and handshake pressures. Each item's expected result comes from
// a bit-exact fixed-point predictor and is checked field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module damaged_shear_modulus_update_unit_tb;

    localparam longint WORD_MAX = 64'sd140737488355327;
    localparam longint WORD_MIN = -64'sd140737488355328;
    localparam longint XI_LIMIT = 64'sd29058990;
    localparam longint Q_ONE    = 64'sd16777216;

    typedef struct packed {
        logic [47:0] lam;
        logic [47:0] shear;
        logic [47:0] gamma;
        logic [46:0] stiff;
        logic        flag;
    } point_result_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [1:0]                  cfg_index;
    logic [dsm_pkg::W-1:0]       cfg_data;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [dsm_pkg::IN_TW-1:0]   s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [dsm_pkg::OUT_TW-1:0]  m_tdata;
    logic [0:0]                  m_tuser;

    logic [dsm_pkg::IN_TW-1:0]   pending_points[$];
    point_result_t               expected_results[$];
    int                          sender_idle;
    int                          recv_stall;
    int                          fail_count;

    // Mirror of the register file as the predictor sees it.
    longint              mir_xi;
    longint              mir_lam;
    longint              mir_mu;
    logic                mir_use;

    damaged_shear_modulus_update_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    // ---------------- fixed-point predictor ----------------

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX)
            return WORD_MAX;
        else if (v < WORD_MIN)
            return WORD_MIN;
        return v;
    endfunction

    function automatic longint qadd(input longint a, input longint b);
        return clamp_word(a + b);
    endfunction

    function automatic longint qneg(input longint a);
        return clamp_word(-a);
    endfunction

    function automatic longint qscale(input longint a, input longint k);
        return clamp_word(a * k);
    endfunction

    function automatic logic [127:0] abs_word(input longint a);
        return (a < 0) ? 128'(-a) : 128'(a);
    endfunction

    function automatic longint signed_from_abs(input logic neg, input logic [127:0] m);
        if (neg)
            return (m > 128'(-WORD_MIN)) ? WORD_MIN : -longint'(m[63:0]);
        return (m > 128'(WORD_MAX)) ? WORD_MAX : longint'(m[63:0]);
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        logic [127:0] p;
        p = abs_word(a) * abs_word(b) + (128'(1) << (dsm_pkg::F - 1));
        return signed_from_abs((a < 0) != (b < 0), p >> dsm_pkg::F);
    endfunction

    function automatic longint qdiv(input longint n, input longint d);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] r;
        num = abs_word(n) << dsm_pkg::F;
        den = abs_word(d);
        q = num / den;
        r = num % den;
        if ((r << 1) >= den)
            q = q + 1;
        return signed_from_abs((n < 0) != (d < 0), q);
    endfunction

    function automatic logic [63:0] floor_root(input logic [127:0] n);
        logic [63:0]  r;
        logic [127:0] c;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            c = 128'(r | (64'd1 << b));
            if (n >= c * c)
                r = c[63:0];
        end
        return r;
    endfunction

    function automatic point_result_t predict_point(input logic [dsm_pkg::IN_TW-1:0] pt);
        point_result_t res;
        longint d0, lam, mu, x, x2, x4, denom, gam, mu_eff;
        longint lx2, mu2, t1, r1, r2, t2, gm, gp, bm;
        logic   flag;
        d0 = longint'(pt[24:0]);
        lam = mir_use ? longint'($signed(pt[72:25])) : mir_lam;
        mu  = mir_use ? longint'($signed(pt[120:73])) : mir_mu;
        x = mir_xi;
        x2 = qmul(x, x);
        x4 = qmul(x2, x2);
        denom = qscale(qadd(x2, qneg(qscale(Q_ONE, 3))), 2);
        gam = 0;
        flag = 1'b0;
        if (denom == 0)
            flag = 1'b1;
        else
        begin
            lx2 = qmul(lam, x2);
            mu2 = qscale(mu, 2);
            t1 = qneg(qmul(x, qadd(qadd(qneg(lx2), qscale(lam, 6)), mu2)));
            r1 = qadd(lx2, mu2);
            r2 = qmul(lam, x4);
            r2 = qadd(r2, qneg(qscale(lx2, 12)));
            r2 = qadd(r2, qscale(lam, 36));
            r2 = qadd(r2, qneg(qscale(qmul(mu, x2), 6)));
            r2 = qadd(r2, qscale(mu, 24));
            t2 = 0;
            // A radicand below zero contributes no root term.
            if (((r1 < 0) == (r2 < 0)) || r1 == 0 || r2 == 0)
                t2 = signed_from_abs(1'b0,
                                     128'(floor_root(abs_word(r1) * abs_word(r2))));
            gm = qdiv(qadd(t1, qneg(t2)), denom);
            gp = qdiv(qadd(t1, t2), denom);
            bm = qadd(mu2, qneg(qmul(gm, x)));
            gam = (bm > 0) ? gm : gp;
        end
        mu_eff = qadd(mu, qmul(qmul(x, d0), gam));
        res.lam   = lam[47:0];
        res.shear = mu_eff[47:0];
        res.gamma = gam[47:0];
        res.stiff = (mu_eff > 0) ? 47'(floor_root(128'(mu_eff) << dsm_pkg::F)) : '0;
        res.flag  = flag;
        return res;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic longint rand_modulus();
        longint v;
        case ($urandom_range(3))
            0: v = longint'($signed({$urandom, $urandom} & 64'hFFFF_FFFF_FFFF) <<< 16) >>> 16;
            1: v = longint'($urandom_range(0, 100 << 24));
            2: v = longint'($urandom) <<< 8;
            default:
            begin
                case ($urandom_range(4))
                    0: v = WORD_MAX;
                    1: v = WORD_MIN;
                    2: v = 0;
                    3: v = 1;
                    default: v = -1;
                endcase
            end
        endcase
        if ($urandom_range(1) && v != WORD_MIN)
            v = -v;
        return v;
    endfunction

    function automatic longint rand_ratio();
        longint v;
        case ($urandom_range(3))
            0: v = longint'($urandom_range(0, 2 * XI_LIMIT)) - XI_LIMIT;
            1: v = XI_LIMIT - longint'($urandom_range(0, 3));
            2: v = longint'($urandom_range(0, 2 * Q_ONE));
            default: v = ($urandom_range(1)) ? XI_LIMIT : 0;
        endcase
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic logic [dsm_pkg::IN_TW-1:0] make_point(input longint d0,
                                                              input longint lam,
                                                              input longint mu);
        return {7'd0, mu[47:0], lam[47:0], d0[24:0]};
    endfunction

    function automatic logic [dsm_pkg::IN_TW-1:0] rand_point();
        longint d0;
        case ($urandom_range(3))
            0: d0 = Q_ONE;
            1: d0 = 0;
            default: d0 = longint'($urandom_range(0, Q_ONE));
        endcase
        return make_point(d0, rand_modulus(), rand_modulus());
    endfunction

    task automatic write_reg(input logic [1:0] idx, input longint value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[47:0];
        case (idx)
            dsm_pkg::REG_XI:  mir_xi  = value;
            dsm_pkg::REG_LAM: mir_lam = value;
            dsm_pkg::REG_MU:  mir_mu  = value;
            default: mir_use = value[0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(input longint xi, input longint lam, input longint mu,
                           input logic use_pt);
        write_reg(dsm_pkg::REG_XI, xi);
        write_reg(dsm_pkg::REG_LAM, lam);
        write_reg(dsm_pkg::REG_MU, mu);
        write_reg(dsm_pkg::REG_USE, longint'(use_pt));
    endtask

    task automatic drain();
        while (pending_points.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // ---------------- driver ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_point(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (pending_points.size() != 0 && $urandom_range(99) >= sender_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_points.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        point_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[47:0] !== want.lam)
                    begin
                        $error("lambda_out expected %h actual %h", want.lam, m_tdata[47:0]);
                        fail_count++;
                    end
                    if (m_tdata[95:48] !== want.shear)
                    begin
                        $error("shear_effective expected %h actual %h",
                               want.shear, m_tdata[95:48]);
                        fail_count++;
                    end
                    if (m_tdata[143:96] !== want.gamma)
                    begin
                        $error("coupling_modulus expected %h actual %h",
                               want.gamma, m_tdata[143:96]);
                        fail_count++;
                    end
                    if (m_tdata[190:144] !== want.stiff)
                    begin
                        $error("stiffness_estimate expected %h actual %h",
                               want.stiff, m_tdata[190:144]);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.flag)
                    begin
                        $error("degenerate_flag expected %b actual %b", want.flag, m_tuser[0]);
                        fail_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        int idle_tab[4];
        int stall_tab[4];
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        sender_idle = 0;
        recv_stall = 0;
        fail_count = 0;
        mir_xi = 0;
        mir_lam = 0;
        mir_mu = 0;
        mir_use = 1'b0;
        idle_tab = '{0, 60, 0, 37};
        stall_tab = '{0, 0, 60, 37};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Registers at reset value: zero ratio, fallback moduli zero.
        pending_points.push_back(make_point(Q_ONE, 1, 1));
        drain();

        // Field extremes with point moduli enabled.
        set_all(Q_ONE, 0, 0, 1'b1);
        pending_points.push_back(make_point(0, WORD_MAX, WORD_MAX));
        pending_points.push_back(make_point(Q_ONE, WORD_MIN, WORD_MIN));
        pending_points.push_back(make_point(Q_ONE, WORD_MAX, WORD_MIN));
        pending_points.push_back(make_point(Q_ONE / 2, 10 << 24, 5 << 24));
        pending_points.push_back(make_point(Q_ONE, -(10 << 24), 3 << 24));
        pending_points.push_back(make_point(1, -1, -1));
        drain();

        // Ratio extremes; at the ratio limit the denominator comes close to zero.
        set_all(XI_LIMIT, 7 << 24, 3 << 24, 1'b0);
        pending_points.push_back(make_point(Q_ONE, 0, 0));
        pending_points.push_back(make_point(0, 0, 0));
        drain();
        set_all(-XI_LIMIT, WORD_MAX, WORD_MIN, 1'b0);
        pending_points.push_back(make_point(Q_ONE, 0, 0));
        pending_points.push_back(make_point(Q_ONE / 3, 0, 0));
        drain();
        set_all(XI_LIMIT - 1, WORD_MIN, WORD_MAX, 1'b0);
        pending_points.push_back(make_point(Q_ONE, 0, 0));
        drain();

        // Radicand negative versus positive, mu_eff driven below zero.
        set_all(Q_ONE, 0, 0, 1'b1);
        pending_points.push_back(make_point(Q_ONE, -(50 << 24), 1 << 24));
        pending_points.push_back(make_point(Q_ONE, 50 << 24, -(1 << 24)));
        pending_points.push_back(make_point(Q_ONE, 1 << 24, -(40 << 24)));
        pending_points.push_back(make_point(Q_ONE, 2 << 24, 1 << 24));
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle = idle_tab[ph];
            recv_stall  = stall_tab[ph];
            for (int s = 0; s < 5; s++)
            begin
                set_all(rand_ratio(), rand_modulus(), rand_modulus(), $urandom_range(3) != 0);
                for (int k = 0; k < 35; k++)
                    pending_points.push_back(rand_point());
                drain();
            end
        end

        sender_idle = 0;
        recv_stall = 0;
        drain();
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("[damaged_shear_modulus_update_unit] OK");
        else
            $display("[damaged_shear_modulus_update_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[damaged_shear_modulus_update_unit] ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/dsm_pkg.sv
rtl/dsm_mul.sv
rtl/dsm_div.sv
rtl/dsm_sqrt.sv
rtl/damaged_shear_modulus_update_unit.sv
tb/damaged_shear_modulus_update_unit_tb.sv
